@@ sv/cmf_pkg.sv @@
// ----------------------------------------------------------------------------
// cmf_pkg: shared constants for the money flow core
// Window depth, field widths and sequencer step counts.
// ----------------------------------------------------------------------------
package cmf_pkg;

	localparam int MAX_PERIOD = 64;
	localparam int PTR_W      = $clog2(MAX_PERIOD);
	localparam int PERIOD_W   = 7;
	localparam int PRICE_W    = 32;
	localparam int FLOW_W     = 33;
	localparam int FSUM_W     = 39;
	localparam int VSUM_W     = 38;
	localparam int RES_W      = 16;
	localparam int BAR_W      = 4 * PRICE_W;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);

	// radix-2 steps for the bar quotient and for the window ratio
	localparam int CNT_W      = 5;
	localparam int BAR_STEPS  = 32;
	localparam int RAT_STEPS  = 16;

	typedef logic [PRICE_W-1:0] price_t;

endpackage

@@ sv/chaikin_money_flow_core.sv @@
// ----------------------------------------------------------------------------
// chaikin_money_flow_core: Chaikin money flow over a sliding window of bars
// Each bar runs the bar-quotient division, updates the window sums and, once the
// window is full and its volume nonzero, the ratio division; a new bar is taken
// only back in idle, so a stalled result register holds off the next bar.
// Reset clears window, sums and pointers and loads period 20; stores are not
// cleared, entries are only used after being written since the last clear.
// ----------------------------------------------------------------------------
module chaikin_money_flow_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// config: period
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cmf_pkg::PERIOD_W-1:0] cfg_data,
	// tdata: bar_high, bar_low, bar_close, bar_volume (lowest bits first)
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [cmf_pkg::BAR_W-1:0]   s_axis_tdata,
	// tuser: start_series
	input  logic [0:0]                  s_axis_tuser,
	// tdata: money_flow
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [cmf_pkg::RES_W-1:0]   m_axis_tdata,
	// tuser: zero_volume
	output logic [0:0]                  m_axis_tuser
);
	import cmf_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PREP = 4'd1;
	localparam logic [3:0] ST_MUL  = 4'd2;
	localparam logic [3:0] ST_DIV1 = 4'd3;
	localparam logic [3:0] ST_SUB  = 4'd4;
	localparam logic [3:0] ST_ADD  = 4'd5;
	localparam logic [3:0] ST_FIN  = 4'd6;
	localparam logic [3:0] ST_DIV2 = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;

	// window stores
	logic [FLOW_W-1:0]  flow_mem [MAX_PERIOD];
	price_t             vol_mem  [MAX_PERIOD];
	logic [FLOW_W-1:0]  old_flow_q;
	price_t             old_vol_q;

	logic [PERIOD_W-1:0] period_q;
	logic [PTR_W-1:0]    wp_q;
	logic [PERIOD_W-1:0] fill_q;
	logic [FSUM_W-1:0]   fsum_q;
	logic [VSUM_W-1:0]   vsum_q;

	// bar registers
	price_t hi_q, lo_bar_q, cl_q, vol_q;
	logic   neg_q, sat_q, flat_q, zero_q;
	logic [FLOW_W-1:0] mfv_q;

	// shared divider
	logic [VSUM_W-1:0]  rem_q;
	logic [VSUM_W-1:0]  div_q;
	logic [PRICE_W-1:0] sh_q;
	logic [CNT_W-1:0]   cnt_q;

	logic                 in_acc, cfg_acc;
	logic [PERIOD_W-1:0]  eff_period;
	logic [PRICE_W-1:0]   den;
	logic [PRICE_W:0]     up2, dn2, mag33;
	logic                 up_ge;
	logic [2*PRICE_W-1:0] prod;
	logic [VSUM_W:0]      dv_t, dv_d;
	logic                 dv_ge;
	logic [PRICE_W-1:0]   mfv_mag;
	logic [FSUM_W-1:0]    fs_abs;
	logic [RES_W-1:0]     quo, res;
	logic                 out_free;

	// take period writes only between bars; hold bars off while one is offered
	assign cfg_ready     = (state_q == ST_IDLE);
	assign cfg_acc       = cfg_valid & cfg_ready;
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	always_comb begin
		if (cfg_data == '0) begin
			eff_period = PERIOD_W'(1);
		end else if (cfg_data > PERIOD_W'(MAX_PERIOD)) begin
			eff_period = PERIOD_W'(MAX_PERIOD);
		end else begin
			eff_period = cfg_data;
		end
	end

	// bar flow operands
	assign den   = hi_q - lo_bar_q;
	assign up2   = {cl_q, 1'b0};
	assign dn2   = {1'b0, lo_bar_q} + {1'b0, hi_q};
	assign up_ge = (up2 >= dn2);
	assign mag33 = up_ge ? (up2 - dn2) : (dn2 - up2);
	assign prod  = {{PRICE_W{1'b0}}, sh_q} * {{PRICE_W{1'b0}}, vol_q};

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign dv_t  = {rem_q, sh_q[PRICE_W-1]};
	assign dv_d  = dv_t - {1'b0, div_q};
	assign dv_ge = (dv_t >= {1'b0, div_q});

	assign mfv_mag = flat_q ? '0 : (sat_q ? vol_q : sh_q);
	assign fs_abs  = fsum_q[FSUM_W-1] ? (FSUM_W'(0) - fsum_q) : fsum_q;

	assign quo = sh_q[RES_W-1:0];
	always_comb begin
		if (zero_q) begin
			res = '0;
		end else if (neg_q) begin
			res = RES_W'(0) - quo;
		end else if (quo[RES_W-1]) begin
			res = {1'b0, {(RES_W-1){1'b1}}};
		end else begin
			res = quo;
		end
	end

	// store access: read the slot at request, write it back as the sums are updated
	always_ff @(posedge clk) begin
		if (in_acc) begin
			old_flow_q <= flow_mem[wp_q];
			old_vol_q  <= vol_mem[wp_q];
		end
		if (state_q == ST_ADD) begin
			flow_mem[wp_q] <= mfv_q;
			vol_mem[wp_q]  <= vol_q;
		end
	end

	// payload and divider datapath
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_IDLE: begin
				if (in_acc) begin
					hi_q     <= s_axis_tdata[PRICE_W-1:0];
					lo_bar_q <= s_axis_tdata[2*PRICE_W-1:PRICE_W];
					cl_q     <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
					vol_q    <= s_axis_tdata[4*PRICE_W-1:3*PRICE_W];
				end
			end
			ST_PREP: begin
				flat_q <= !(hi_q > lo_bar_q);
				neg_q  <= !up_ge;
				sat_q  <= (mag33 >= {1'b0, den});
				sh_q   <= mag33[PRICE_W-1:0];
				div_q  <= VSUM_W'(den);
			end
			ST_MUL: begin
				rem_q <= VSUM_W'(prod[2*PRICE_W-1:PRICE_W]);
				sh_q  <= prod[PRICE_W-1:0];
				cnt_q <= CNT_W'(BAR_STEPS - 1);
			end
			ST_DIV1, ST_DIV2: begin
				rem_q <= dv_ge ? dv_d[VSUM_W-1:0] : dv_t[VSUM_W-1:0];
				sh_q  <= {sh_q[PRICE_W-2:0], dv_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			ST_SUB: begin
				mfv_q <= neg_q ? (FLOW_W'(0) - {1'b0, mfv_mag}) : {1'b0, mfv_mag};
			end
			ST_FIN: begin
				// dividend is |flow_sum| * 2^15; quotient fits 16 steps since
				// |flow_sum| never exceeds volume_sum
				zero_q <= (vsum_q == '0);
				neg_q  <= fsum_q[FSUM_W-1];
				rem_q  <= {1'b0, fs_abs[VSUM_W-1:1]};
				sh_q   <= {fs_abs[0], {(PRICE_W-1){1'b0}}};
				div_q  <= vsum_q;
				cnt_q  <= CNT_W'(RAT_STEPS - 1);
			end
			default: begin
			end
		endcase
	end

	// sequencer, window bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			period_q      <= PERIOD_RESET;
			wp_q          <= '0;
			fill_q        <= '0;
			fsum_q        <= '0;
			vsum_q        <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_axis_tuser[0]) begin
							wp_q   <= '0;
							fill_q <= '0;
							fsum_q <= '0;
							vsum_q <= '0;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_DIV1;
				ST_DIV1: begin
					if (cnt_q == '0) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					// drop the bar leaving the window
					if (fill_q >= period_q) begin
						fsum_q <= fsum_q - {{(FSUM_W-FLOW_W){old_flow_q[FLOW_W-1]}}, old_flow_q};
						vsum_q <= vsum_q - VSUM_W'(old_vol_q);
					end else begin
						fill_q <= fill_q + PERIOD_W'(1);
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					fsum_q <= fsum_q + {{(FSUM_W-FLOW_W){mfv_q[FLOW_W-1]}}, mfv_q};
					vsum_q <= vsum_q + VSUM_W'(vol_q);
					if (PERIOD_W'(wp_q) + PERIOD_W'(1) >= period_q) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + PTR_W'(1);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fill_q < period_q) begin
						state_q <= ST_IDLE;
					end else if (vsum_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (cnt_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						m_axis_tvalid   <= 1'b1;
						m_axis_tdata    <= res;
						m_axis_tuser[0] <= zero_q;
						state_q         <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_acc) begin
				period_q <= eff_period;
				wp_q     <= '0;
				fill_q   <= '0;
				fsum_q   <= '0;
				vsum_q   <= '0;
			end
		end
	end

endmodule

@@ tb/sv/chaikin_money_flow_core_tb.sv @@
// ----------------------------------------------------------------------------
// chaikin_money_flow_core_tb: self-checking bench for the money flow core
// Streams price bars through the core under random stalls on both sides and
// checks each ratio against a window model kept in the bench or, for typed rows,
// against the directed table; the table covers edge cases, then random phases sweep period.
// ----------------------------------------------------------------------------
module chaikin_money_flow_core_tb;
	import cmf_pkg::*;

	localparam int PERIOD_NS  = 12;
	localparam int IDLE_PCT   = 13;
	localparam int DRAIN_WAIT = 64;
	localparam int SINK_HOLD  = 600;
	localparam int WDOG_LIMIT = 5000;
	localparam int NUM_ROWS   = 23;
	localparam int NUM_PHASES = 10;
	localparam price_t PMAX   = '1;

	localparam int PLAN_PERIOD [NUM_PHASES] = '{64, 127, 65, 1, 0, 2, 3, -1, -1, -1};
	localparam int PLAN_BARS   [NUM_PHASES] = '{150, 120, 100, 150, 50, 100, 100, 110, 110, 110};

	typedef enum logic {ROW_BAR, ROW_PERIOD} row_kind_t;

	typedef struct packed {
		logic [RES_W-1:0] flow;
		logic             zero;
	} result_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [PERIOD_W-1:0]   period;
		logic                  start;
		price_t                hi;
		price_t                lo;
		price_t                cl;
		price_t                vol;
		logic                  typed;
		logic [RES_W-1:0]      exp_flow;
		logic                  exp_zero;
	} dir_row_t;

	// directed rows: the first three go into the default window without a result
	localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
		'{ROW_BAR,    7'd0,   1'b1, 32'd100, 32'd50, 32'd75,  32'd10,   1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd200, 32'd100, 32'd200, 32'd500, 1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, PMAX,    32'd0,  32'd0,   PMAX,     1'b0, 16'h0000, 1'b0},
		'{ROW_PERIOD, 7'd1,   1'b0, 32'd0,   32'd0,  32'd0,   32'd0,    1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd100, 32'd1000, 1'b1, 16'h7fff, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd50,  32'd1000, 1'b1, 16'h8000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd75,  32'd1000, 1'b1, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd90,  32'd0,    1'b1, 16'h0000, 1'b1},
		'{ROW_BAR,    7'd0,   1'b0, 32'd50,  32'd50, 32'd50,  32'd77,   1'b1, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd40,  32'd50, 32'd45,  32'd77,   1'b1, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, PMAX,    32'd7,    1'b1, 16'h7fff, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd0,   32'd7,    1'b1, 16'h8000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b1, PMAX,    32'd0,  PMAX,    PMAX,     1'b1, 16'h7fff, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, PMAX,    32'd0,  32'd0,   PMAX,     1'b1, 16'h8000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, PMAX,    PMAX-1, PMAX,    32'd1,    1'b1, 16'h7fff, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd0,   32'd0,  32'd0,   32'd0,    1'b1, 16'h0000, 1'b1},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd0,  32'd75,  32'd4,    1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd0,  32'd25,  32'd3,    1'b0, 16'h0000, 1'b0},
		'{ROW_PERIOD, 7'd0,   1'b0, 32'd0,   32'd0,  32'd0,   32'd0,    1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd100, 32'd9,    1'b1, 16'h7fff, 1'b0},
		'{ROW_PERIOD, 7'd2,   1'b0, 32'd0,   32'd0,  32'd0,   32'd0,    1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd100, 32'd100,  1'b0, 16'h0000, 1'b0},
		'{ROW_BAR,    7'd0,   1'b0, 32'd100, 32'd50, 32'd50,  32'd100,  1'b1, 16'h0000, 1'b0}
	};

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [PERIOD_W-1:0] cfg_data      = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [BAR_W-1:0]    s_axis_tdata  = '0;
	logic [0:0]          s_axis_tuser  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [RES_W-1:0]    m_axis_tdata;
	logic [0:0]          m_axis_tuser;

	// window model
	longint              flow_ring   [MAX_PERIOD];
	longint unsigned     volume_ring [MAX_PERIOD];
	int unsigned         ring_ptr;
	int unsigned         ring_fill;
	longint              flow_total;
	longint unsigned     volume_total;
	logic [PERIOD_W-1:0] window_len;

	result_t money_flow_q [$];
	int      fail_count    = 0;
	bit      steady        = 1'b0;
	bit      sink_hold_req = 1'b0;

	chaikin_money_flow_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(PERIOD_NS / 2) clk = ~clk;

	function automatic void clear_window();
		ring_ptr     = 0;
		ring_fill    = 0;
		flow_total   = 0;
		volume_total = 0;
	endfunction

	// advance the window by one bar; returns 1 when the bar yields a ratio
	function automatic bit predict_money_flow(input bit start, input price_t hi, input price_t lo,
			input price_t cl, input price_t vol, output result_t res);
		longint unsigned den, up, dn, mag;
		longint          mfv, q;
		int unsigned     win, slot;
		bit              neg;
		win = (window_len == 0) ? 1 : (window_len > MAX_PERIOD) ? MAX_PERIOD : window_len;
		res = '0;
		if (start)
			clear_window();
		mfv = 0;
		if (hi > lo) begin
			den = 64'(hi) - 64'(lo);
			up  = 2 * 64'(cl);
			dn  = 64'(lo) + 64'(hi);
			neg = (up < dn);
			mag = neg ? dn - up : up - dn;
			// close outside the bar range clamps to the full volume
			if (mag >= den)
				mag = 64'(vol);
			else
				mag = (mag * 64'(vol)) / den;
			mfv = neg ? -longint'(mag) : longint'(mag);
		end
		slot = ring_ptr % win;
		if (ring_fill >= win) begin
			flow_total   -= flow_ring[slot];
			volume_total -= volume_ring[slot];
		end else begin
			ring_fill++;
		end
		flow_ring[slot]   = mfv;
		volume_ring[slot] = 64'(vol);
		flow_total       += mfv;
		volume_total     += 64'(vol);
		ring_ptr = (slot + 1 >= win) ? 0 : slot + 1;
		if (ring_fill < win)
			return 1'b0;
		if (volume_total == 0) begin
			res.zero = 1'b1;
			return 1'b1;
		end
		neg = (flow_total < 0);
		mag = neg ? longint'(-flow_total) : longint'(flow_total);
		mag = (mag * 32768) / volume_total;
		if (mag > 32768)
			mag = 32768;
		q = neg ? -longint'(mag) : longint'(mag);
		if (q > 32767)
			q = 32767;
		res.flow = q[RES_W-1:0];
		return 1'b1;
	endfunction

	// drop valid, let every pending ratio arrive, then let a silent bar finish
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (money_flow_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_period(input logic [PERIOD_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		window_len  = value;
		clear_window();
	endtask

	task automatic send_bar(input bit start, input price_t hi, input price_t lo, input price_t cl,
			input price_t vol, input bit typed, input result_t typed_res);
		result_t res;
		bit      has;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {vol, cl, lo, hi};
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		has = predict_money_flow(start, hi, lo, cl, vol, res);
		if (typed)
			money_flow_q.push_back(typed_res);
		else if (has)
			money_flow_q.push_back(res);
	endtask

	task automatic make_bar(output bit start, output price_t hi, output price_t lo,
			output price_t cl, output price_t vol);
		int unsigned pick;
		price_t      span, tmp;
		pick  = $urandom_range(0, 99);
		start = ($urandom_range(0, 199) == 0);
		if (pick < 75) begin
			hi = $urandom;
			if (hi == 0)
				hi = 1;
			span = $urandom_range(0, 1) ? $urandom_range(1, 1000) : $urandom_range(1, hi);
			if (span > hi)
				span = hi;
			lo = hi - span;
			cl = lo + $urandom_range(0, span);
		end else begin
			hi = $urandom;
			lo = $urandom;
			cl = $urandom;
			case (pick % 4)
				0: lo = hi;
				1: cl = '0;
				2: cl = '1;
				default: begin
					if (hi > lo) begin
						tmp = hi;
						hi  = lo;
						lo  = tmp;
					end
				end
			endcase
		end
		case ($urandom_range(0, 9)) inside
			0:       vol = '0;
			1, 2:    vol = $urandom_range(0, 1000);
			3:       vol = '1;
			default: vol = $urandom;
		endcase
	endtask

	// result side: check each accepted ratio, stall at random or on request
	initial begin
		result_t     want;
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (money_flow_q.size() == 0) begin
					$display("%0t: unexpected result flow %0d zero %0b", $time,
						$signed(m_axis_tdata), m_axis_tuser[0]);
					fail_count++;
				end else begin
					want = money_flow_q.pop_front();
					if (m_axis_tdata !== want.flow) begin
						$display("%0t: money_flow expected %0d got %0d", $time,
							$signed(want.flow), $signed(m_axis_tdata));
						fail_count++;
					end
					if (m_axis_tuser[0] !== want.zero) begin
						$display("%0t: zero_volume expected %0b got %0b", $time,
							want.zero, m_axis_tuser[0]);
						fail_count++;
					end
				end
			end
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left     = SINK_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= arst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// stall watchdog: any accepted transfer on any channel counts as progress
	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d ratios outstanding", $time,
					money_flow_q.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		bit          start;
		price_t      hi, lo, cl, vol;
		int          period;
		result_t     typed_res;
		window_len = PERIOD_RESET;
		clear_window();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_PERIOD) begin
				write_period(DIR_ROWS[i].period);
			end else begin
				typed_res.flow = DIR_ROWS[i].exp_flow;
				typed_res.zero = DIR_ROWS[i].exp_zero;
				send_bar(DIR_ROWS[i].start, DIR_ROWS[i].hi, DIR_ROWS[i].lo, DIR_ROWS[i].cl,
					DIR_ROWS[i].vol, DIR_ROWS[i].typed, typed_res);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			period = (PLAN_PERIOD[ph] < 0) ? $urandom_range(4, 63) : PLAN_PERIOD[ph];
			write_period(period[PERIOD_W-1:0]);
			steady = (ph == 6);
			// single-bar window: hold the result side so the core backs up
			if (ph == 3)
				sink_hold_req = 1'b1;
			for (int n = 0; n < PLAN_BARS[ph]; n++) begin
				if (ph == 0 && n == PLAN_BARS[ph] / 2)
					wait_idle();
				make_bar(start, hi, lo, cl, vol);
				send_bar(start, hi, lo, cl, vol, 1'b0, '0);
			end
			steady = 1'b0;
		end

		wait_idle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
